[hdl/smdu_pkg.sv]
// Shared constants, codes and the sideband type of the scaled multiply/divide unit.
package smdu_pkg;

    localparam int DATA_W     = 32;
    localparam int LIM_W      = 31;
    localparam int DSM_W      = 16;
    localparam int RADIX_LOG2 = 15;
    localparam int QUO_OVF_BIT = 2 * RADIX_LOG2;   // mul-div quotient limit 2^30
    localparam int DVD_W      = 48;                // divider dividend / quotient width
    localparam int DIV_STEPS  = DVD_W;             // one quotient bit per stage
    localparam int PROD_W     = 64;
    localparam int THR_W      = 35;                // limit-check thresholds

    localparam logic signed [THR_W-1:0] MAX_MAG = THR_W'(64'sd2147483647);

    typedef enum logic [1:0] {
        ACT_MUL_ADD = 2'd0,
        ACT_DIV     = 2'd1,
        ACT_MUL_DIV = 2'd2,
        ACT_RSVD    = 2'd3
    } action_t;

    // Travels beside the divider; preset result for items that need no divide.
    typedef struct packed {
        logic              use_div;
        logic              is_mul_div;
        logic              neg_q;
        logic              neg_r;
        logic              flag;
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] rem;
    } side_t;

endpackage

[hdl/smdu_front.sv]
// Front stages: operand magnitudes, multiplier, multiply-add limit checks, divider setup.
module smdu_front
    import smdu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic [1:0]               in_action,
    input  logic [DATA_W-1:0]        in_x,
    input  logic [DATA_W-1:0]        in_n,
    input  logic [DATA_W-1:0]        in_y,
    input  logic [LIM_W-1:0]         in_lim,
    input  logic [DSM_W-1:0]         in_d,
    output logic                     out_valid,
    output logic [DVD_W-1:0]         out_dividend,
    output logic [DATA_W-1:0]        out_divisor,
    output side_t                    out_side
);

    // stage 1: input register
    logic v1_reg;
    logic [1:0] act1_reg;
    logic [DATA_W-1:0] x1_reg, n1_reg, y1_reg;
    logic [LIM_W-1:0] lim1_reg;
    logic [DSM_W-1:0] d1_reg;

    // stage 2: magnitudes, limit differences
    logic v2_reg;
    logic [1:0] act2_reg;
    logic sx2_reg, sn2_reg, nz2_reg, nhi2_reg;
    logic [DATA_W-1:0] x2_reg, y2_reg, mx2_reg, mn2_reg;
    logic [DSM_W-1:0] d2_reg;
    logic signed [THR_W-1:0] a2_reg, b2_reg;

    // stage 3: product, thresholds
    logic v3_reg;
    logic [1:0] act3_reg;
    logic sx3_reg, sn3_reg, nz3_reg, nhi3_reg;
    logic [DATA_W-1:0] x3_reg, y3_reg, mn3_reg;
    logic [DSM_W-1:0] d3_reg;
    logic [PROD_W-1:0] prod3_reg;
    logic signed [THR_W-1:0] thra3_reg, thrb3_reg, hi3_reg, lo3_reg;

    // stage 4: signed product
    logic v4_reg;
    logic [1:0] act4_reg;
    logic sx4_reg, sn4_reg, nz4_reg, nhi4_reg;
    logic [DATA_W-1:0] x4_reg, y4_reg, mn4_reg;
    logic [DSM_W-1:0] d4_reg;
    logic [DVD_W-1:0] prodl4_reg;
    logic signed [PROD_W-1:0] p4_reg;
    logic signed [THR_W-1:0] thra4_reg, nthrb4_reg, hi4_reg, lo4_reg;

    // stage 5 (outputs)
    logic v5_reg;
    logic [DVD_W-1:0] dvd5_reg;
    logic [DATA_W-1:0] dvs5_reg;
    side_t side5_reg;

    function automatic logic signed [PROD_W-1:0] ext_thr(input logic signed [THR_W-1:0] v);
        ext_thr = PROD_W'(v);
    endfunction

    // stage 2 logic
    logic [DATA_W-1:0] mx2_next, mn2_next;
    logic signed [THR_W-1:0] a2_next, b2_next, y1_ext;
    always_comb
    begin
        mx2_next = x1_reg[DATA_W-1] ? DATA_W'(-x1_reg) : x1_reg;
        mn2_next = n1_reg[DATA_W-1] ? DATA_W'(-n1_reg) : n1_reg;
        y1_ext   = THR_W'($signed(y1_reg));
        a2_next  = $signed({{(THR_W-LIM_W){1'b0}}, lim1_reg}) - y1_ext;
        b2_next  = $signed({{(THR_W-LIM_W){1'b0}}, lim1_reg}) + y1_ext;
    end

    // stage 3 logic
    logic [PROD_W-1:0] prod3_next;
    logic signed [THR_W-1:0] mn2_ext, y2_ext, thra3_next, thrb3_next;
    always_comb
    begin
        prod3_next = PROD_W'(mx2_reg) * PROD_W'(mn2_reg);
        mn2_ext    = $signed({{(THR_W-DATA_W){1'b0}}, mn2_reg});
        y2_ext     = THR_W'($signed(y2_reg));
        // truncating divide of a negative bound rounds up: x <= ceil(a/n) <=> n*x <= a+n-1
        thra3_next = a2_reg[THR_W-1] ? a2_reg + mn2_ext - THR_W'(1) : a2_reg;
        thrb3_next = b2_reg[THR_W-1] ? b2_reg + mn2_ext - THR_W'(1) : b2_reg;
    end

    // stage 5 logic
    logic ok5;
    logic [DVD_W-1:0] dvd5_next;
    logic [DATA_W-1:0] dvs5_next;
    side_t side5_next;
    always_comb
    begin
        ok5 = (p4_reg <= ext_thr(thra4_reg)) && (p4_reg >= ext_thr(nthrb4_reg))
              && (p4_reg <= ext_thr(hi4_reg)) && (p4_reg >= ext_thr(lo4_reg));
        dvd5_next  = '0;
        dvs5_next  = DATA_W'(1);
        side5_next = '0;
        unique case (action_t'(act4_reg))
            ACT_MUL_ADD:
            begin
                if (nz4_reg)
                    side5_next.res = y4_reg;
                else if (ok5)
                    side5_next.res = p4_reg[DATA_W-1:0] + y4_reg;
                else
                    side5_next.flag = 1'b1;
            end
            ACT_DIV:
            begin
                if (nz4_reg)
                begin
                    side5_next.flag = 1'b1;
                    side5_next.rem  = x4_reg;
                end
                else
                begin
                    side5_next.use_div = 1'b1;
                    side5_next.neg_q   = sx4_reg ^ sn4_reg;
                    side5_next.neg_r   = sx4_reg;
                    dvd5_next = {{(DVD_W-DATA_W){1'b0}},
                                 (x4_reg[DATA_W-1] ? DATA_W'(-x4_reg) : x4_reg)};
                    dvs5_next = mn4_reg;
                end
            end
            ACT_MUL_DIV:
            begin
                if (d4_reg == '0 || nhi4_reg)
                    side5_next.flag = 1'b1;
                else
                begin
                    side5_next.use_div    = 1'b1;
                    side5_next.is_mul_div = 1'b1;
                    side5_next.neg_q      = sx4_reg;
                    side5_next.neg_r      = sx4_reg;
                    dvd5_next = prodl4_reg;
                    dvs5_next = {{(DATA_W-DSM_W){1'b0}}, d4_reg};
                end
            end
            ACT_RSVD:
                side5_next.flag = 1'b1;
            default:
                side5_next.flag = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            act1_reg <= in_action;
            x1_reg   <= in_x;
            n1_reg   <= in_n;
            y1_reg   <= in_y;
            lim1_reg <= in_lim;
            d1_reg   <= in_d;

            act2_reg <= act1_reg;
            sx2_reg  <= x1_reg[DATA_W-1];
            sn2_reg  <= n1_reg[DATA_W-1];
            nz2_reg  <= (n1_reg == '0);
            nhi2_reg <= (n1_reg[DATA_W-1:DSM_W] != '0);
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            mx2_reg  <= mx2_next;
            mn2_reg  <= mn2_next;
            d2_reg   <= d1_reg;
            a2_reg   <= a2_next;
            b2_reg   <= b2_next;

            act3_reg  <= act2_reg;
            sx3_reg   <= sx2_reg;
            sn3_reg   <= sn2_reg;
            nz3_reg   <= nz2_reg;
            nhi3_reg  <= nhi2_reg;
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
            mn3_reg   <= mn2_reg;
            d3_reg    <= d2_reg;
            prod3_reg <= prod3_next;
            thra3_reg <= thra3_next;
            thrb3_reg <= thrb3_next;
            hi3_reg   <= MAX_MAG - y2_ext;
            lo3_reg   <= -MAX_MAG - y2_ext;

            act4_reg   <= act3_reg;
            sx4_reg    <= sx3_reg;
            sn4_reg    <= sn3_reg;
            nz4_reg    <= nz3_reg;
            nhi4_reg   <= nhi3_reg;
            x4_reg     <= x3_reg;
            y4_reg     <= y3_reg;
            mn4_reg    <= mn3_reg;
            d4_reg     <= d3_reg;
            prodl4_reg <= prod3_reg[DVD_W-1:0];
            p4_reg     <= (sx3_reg ^ sn3_reg) ? -$signed(prod3_reg) : $signed(prod3_reg);
            thra4_reg  <= thra3_reg;
            nthrb4_reg <= -thrb3_reg;
            hi4_reg    <= hi3_reg;
            lo4_reg    <= lo3_reg;

            dvd5_reg  <= dvd5_next;
            dvs5_reg  <= dvs5_next;
            side5_reg <= side5_next;
        end
    end

    assign out_valid    = v5_reg;
    assign out_dividend = dvd5_reg;
    assign out_divisor  = dvs5_reg;
    assign out_side     = side5_reg;

endmodule

[hdl/smdu_div.sv]
// Pipelined restoring divider, one quotient bit per stage, sideband carried alongside.
module smdu_div
    import smdu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [DVD_W-1:0]  in_dividend,
    input  logic [DATA_W-1:0] in_divisor,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [DVD_W-1:0]  out_quotient,
    output logic [DATA_W-1:0] out_remainder,
    output side_t             out_side
);

    logic              vld_reg  [DIV_STEPS];
    logic [DATA_W-1:0] rem_reg  [DIV_STEPS];
    logic [DVD_W-1:0]  quo_reg  [DIV_STEPS];
    logic [DATA_W-1:0] dvs_reg  [DIV_STEPS];
    side_t             side_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic              v_in;
        logic [DATA_W-1:0] rem_in, dvs_in;
        logic [DVD_W-1:0]  quo_in;
        side_t             side_in;
        logic [DATA_W:0]   trial, diff;
        logic              ge;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign quo_in  = in_dividend;
            assign dvs_in  = in_divisor;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in    = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign dvs_in  = dvs_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = {rem_in, quo_in[DVD_W-1]};
        assign diff  = trial - {1'b0, dvs_in};
        assign ge    = (trial >= {1'b0, dvs_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
                quo_reg[k]  <= {quo_in[DVD_W-2:0], ge};
                dvs_reg[k]  <= dvs_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid     = vld_reg[DIV_STEPS-1];
    assign out_quotient  = quo_reg[DIV_STEPS-1];
    assign out_remainder = rem_reg[DIV_STEPS-1];
    assign out_side      = side_reg[DIV_STEPS-1];

endmodule

[hdl/smdu_back.sv]
// Output stage: sign fix-up, quotient range checks, result register.
module smdu_back
    import smdu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [DVD_W-1:0]  in_quotient,
    input  logic [DATA_W-1:0] in_remainder,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [DATA_W-1:0] out_result,
    output logic [DATA_W-1:0] out_rem,
    output logic              out_flag
);

    logic              valid_reg;
    logic [DATA_W-1:0] res_reg, rem_reg;
    logic              flag_reg;

    logic [DATA_W-1:0] res_next, rem_next, q_signed, r_signed;
    logic              flag_next;

    always_comb
    begin
        q_signed = in_side.neg_q ? DATA_W'(-in_quotient[DATA_W-1:0])
                                 : in_quotient[DATA_W-1:0];
        r_signed = in_side.neg_r ? DATA_W'(-in_remainder) : in_remainder;
        res_next  = in_side.res;
        rem_next  = in_side.rem;
        flag_next = in_side.flag;
        if (in_side.use_div)
        begin
            res_next  = q_signed;
            rem_next  = r_signed;
            flag_next = 1'b0;
            if (in_side.is_mul_div)
            begin
                // high digit reached the radix: flag, keep the remainder
                if (in_quotient[DVD_W-1:QUO_OVF_BIT] != '0)
                begin
                    res_next  = '0;
                    flag_next = 1'b1;
                end
            end
            else if (in_quotient[DATA_W-1])
            begin
                // only -2^31 divided by 1 or -1 lands here
                res_next  = '0;
                rem_next  = '0;
                flag_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg  <= res_next;
            rem_reg  <= rem_next;
            flag_reg <= flag_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = res_reg;
    assign out_rem    = rem_reg;
    assign out_flag   = flag_reg;

endmodule

[hdl/scaled_mul_div_unit_core.sv]
// Top level of the scaled multiply/divide unit: stream ports and pipeline assembly.
//
// Overflow-checked 32-bit scaled arithmetic, one result beat per input beat, no state
// between beats. tuser selects the action: 0 gives n*x+y checked against the magnitude
// limit, 1 gives x/n truncated with the remainder taking the sign of x, 2 gives x*n/d
// with the remainder taking the sign of x. Overflow, divide by zero, out-of-range
// operands and action 3 raise the flag and return result 0. The unit takes one beat
// every cycle unless stalled. A beat passes five front stages (input register,
// magnitudes, 32x32 multiplier, product sign, limit compares), one stage per quotient
// bit of the 48-bit restoring divider, and the output register. Every beat, even one
// that needs no divide, runs the full pipeline, so results leave in order. The whole
// pipeline holds while a result beat waits at the output; s_axis_tready follows it.
module scaled_mul_div_unit_core
    import smdu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operand_x[31:0], factor_n[63:32], addend_y[95:64], magnitude_limit[126:96],
    // divisor_d[142:127], zero pad[143]
    input  logic [143:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_value[31:0], remainder_value[63:32]
    output logic [63:0]  m_axis_tdata,
    // overflow_flag[0]
    output logic [0:0]   m_axis_tuser
);

    logic adv;    // pipeline advances: output slot empty or being taken

    logic              f_valid;
    logic [DVD_W-1:0]  f_dividend;
    logic [DATA_W-1:0] f_divisor;
    side_t             f_side;

    logic              d_valid;
    logic [DVD_W-1:0]  d_quotient;
    logic [DATA_W-1:0] d_remainder;
    side_t             d_side;

    logic [DATA_W-1:0] res_value, rem_value;
    logic              ovf_flag;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    smdu_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (s_axis_tvalid),
        .in_action    (s_axis_tuser),
        .in_x         (s_axis_tdata[31:0]),
        .in_n         (s_axis_tdata[63:32]),
        .in_y         (s_axis_tdata[95:64]),
        .in_lim       (s_axis_tdata[126:96]),
        .in_d         (s_axis_tdata[142:127]),
        .out_valid    (f_valid),
        .out_dividend (f_dividend),
        .out_divisor  (f_divisor),
        .out_side     (f_side)
    );

    smdu_div u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .in_valid      (f_valid),
        .in_dividend   (f_dividend),
        .in_divisor    (f_divisor),
        .in_side       (f_side),
        .out_valid     (d_valid),
        .out_quotient  (d_quotient),
        .out_remainder (d_remainder),
        .out_side      (d_side)
    );

    smdu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (d_valid),
        .in_quotient  (d_quotient),
        .in_remainder (d_remainder),
        .in_side      (d_side),
        .out_valid    (m_axis_tvalid),
        .out_result   (res_value),
        .out_rem      (rem_value),
        .out_flag     (ovf_flag)
    );

    assign m_axis_tdata = {rem_value, res_value};
    assign m_axis_tuser = ovf_flag;

    // every flagged beat carries a zero result
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("flagged beat with nonzero result");

    // a held output beat stalls the input side
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output stalled");

endmodule

[tb/tb.sv]
// Self-checking testbench for scaled_mul_div_unit_core: directed table plus random beats.
`timescale 1ns / 100ps

module tb;
    import smdu_pkg::*;

    // One result beat as the unit should deliver it
    typedef struct {
        logic signed [31:0] res;
        logic signed [31:0] rem;
        logic               flag;
    } scaled_result_t;

    // Directed row: operands plus an optional hand-written result
    typedef struct {
        action_t            act;
        logic signed [31:0] x;
        logic signed [31:0] n;
        logic signed [31:0] y;
        logic [30:0]        lim;
        logic [15:0]        d;
        bit                 typed;
        logic signed [31:0] res;
        logic signed [31:0] rem;
        logic               flag;
    } op_row_t;

    localparam int NUM_ROWS   = 22;
    localparam int WDOG_LIMIT = 4000;
    localparam int DRAIN_CYC  = 80;
    localparam int RAND_ITEMS = 850;

    localparam logic signed [31:0] MAXP = 32'sh7fffffff;
    localparam logic signed [31:0] MAXN = -32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;
    localparam logic [30:0]        LMAX = 31'h7fffffff;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    scaled_result_t pending_results[$];
    int  fail_count;
    int  beats_in;
    int  beats_out;
    int  flagged_out;
    int  idle_cycles;
    int  tx_idle_pct;
    int  rx_idle_pct;
    int  act_count[4];

    op_row_t op_table[NUM_ROWS] = '{
        // act            x      n             y     lim  d       typed res rem flag
        '{ACT_RSVD,    32'sd5, 32'sd3,      32'sd1, LMAX, 16'd1, 1, 0, 0, 1},
        '{ACT_DIV,     32'sd5, 32'sd0,      32'sd0, LMAX, 16'd1, 1, 0, 5, 1},
        '{ACT_DIV,     MINV,   -32'sd1,     32'sd0, LMAX, 16'd1, 1, 0, 0, 1},
        '{ACT_DIV,     32'sd7, 32'sd2,      32'sd0, LMAX, 16'd1, 1, 3, 1, 0},
        '{ACT_DIV,     -32'sd7, 32'sd2,     32'sd0, LMAX, 16'd1, 1, -3, -1, 0},
        '{ACT_DIV,     MAXP,   MAXN,        32'sd0, LMAX, 16'd1, 1, -1, 0, 0},
        '{ACT_DIV,     MINV,   32'sd1,      32'sd0, LMAX, 16'd1, 0, 0, 0, 0},
        '{ACT_MUL_DIV, 32'sd9, 32'sd3,      32'sd0, LMAX, 16'd0, 1, 0, 0, 1},
        '{ACT_MUL_DIV, 32'sd9, 32'sd65536,  32'sd0, LMAX, 16'd7, 1, 0, 0, 1},
        '{ACT_MUL_DIV, 32'sd9, -32'sd1,     32'sd0, LMAX, 16'd7, 1, 0, 0, 1},
        '{ACT_MUL_DIV, MAXP,   32'sd65535,  32'sd0, LMAX, 16'd1, 0, 0, 0, 0},
        '{ACT_MUL_DIV, MAXN,   32'sd65535,  32'sd0, LMAX, 16'hffff, 0, 0, 0, 0},
        '{ACT_MUL_DIV, -32'sd100, 32'sd3,   32'sd0, LMAX, 16'd7, 0, 0, 0, 0},
        '{ACT_MUL_DIV, MINV,   32'sd1,      32'sd0, 31'd0, 16'd3, 0, 0, 0, 0},
        '{ACT_MUL_ADD, 32'sd4, 32'sd0,      MAXN,   31'd0, 16'd1, 1, MAXN, 0, 0},
        '{ACT_MUL_ADD, MAXP,   32'sd2,      32'sd0, LMAX, 16'd1, 1, 0, 0, 1},
        '{ACT_MUL_ADD, 32'sd3, -32'sd5,     32'sd2, LMAX, 16'd1, 1, -13, 0, 0},
        '{ACT_MUL_ADD, 32'sd3, 32'sd5,      32'sd2, 31'd17, 16'd1, 1, 17, 0, 0},
        '{ACT_MUL_ADD, 32'sd3, 32'sd5,      32'sd2, 31'd16, 16'd1, 0, 0, 0, 0},
        '{ACT_MUL_ADD, -32'sd2, -32'sd1,    MINV,   LMAX, 16'd1, 0, 0, 0, 0},
        '{ACT_MUL_ADD, MINV,   MINV,        MAXP,   LMAX, 16'hffff, 0, 0, 0, 0},
        '{ACT_MUL_ADD, MAXP,   32'sd1,      32'sd0, LMAX, 16'd1, 1, MAXP, 0, 0}
    };

    scaled_mul_div_unit_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bit-exact prediction of one beat; all math widened to 64 bits
    function automatic scaled_result_t scaled_arith(action_t act, longint x, longint n,
                                                     longint y, longint lim, longint d);
        scaled_result_t r;
        longint t;
        longint u;
        longint v;
        longint q;
        longint m;
        bit     neg;
        r = '{0, 0, 1'b1};
        case (act)
            ACT_MUL_ADD:
            begin
                if (n < 0)
                begin
                    n = -n;
                    x = -x;
                end
                if (n == 0)
                    r = '{y[31:0], 0, 1'b0};
                else if (x <= (lim - y) / n && -x <= (lim + y) / n)
                begin
                    m = n * x + y;
                    if (m <= 64'sd2147483647 && m >= -64'sd2147483647)
                        r = '{m[31:0], 0, 1'b0};
                end
            end
            ACT_DIV:
            begin
                if (n == 0)
                    r = '{0, x[31:0], 1'b1};
                else
                begin
                    q = x / n;
                    m = x % n;
                    if (q <= 64'sd2147483647 && q >= -64'sd2147483647)
                        r = '{q[31:0], m[31:0], 1'b0};
                end
            end
            ACT_MUL_DIV:
            begin
                if (d != 0 && n >= 0 && n <= 65535)
                begin
                    neg = (x < 0);
                    if (neg)
                        x = -x;
                    t = (x % 32768) * n;
                    u = (x / 32768) * n + t / 32768;
                    v = (u % d) * 32768 + t % 32768;
                    m = neg ? -(v % d) : v % d;
                    if (u / d >= 32768)
                        r = '{0, m[31:0], 1'b1};
                    else
                    begin
                        q = 32768 * (u / d) + v / d;
                        if (neg)
                            q = -q;
                        r = '{q[31:0], m[31:0], 1'b0};
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Operand mix: extremes, small values and raw 32-bit words
    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0: return $urandom_range(40) - 20;
            1: return $urandom_range(65535);
            2: return -$urandom_range(65535);
            3:
            begin
                case ($urandom_range(3))
                    0: return MAXP;
                    1: return MAXN;
                    2: return MINV;
                    default: return 0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Present one beat and hold it until the unit takes it; expectation queued on accept
    task automatic send_beat(action_t act, logic [31:0] x, logic [31:0] n, logic [31:0] y,
                             logic [30:0] lim, logic [15:0] d, bit typed,
                             scaled_result_t typed_res);
        scaled_result_t exp_res;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {1'b0, d, lim, y, n, x};
        do
            @(posedge clk);
        while (!s_axis_tready);
        exp_res = typed ? typed_res
                        : scaled_arith(act, $signed(x), $signed(n), $signed(y), lim, d);
        pending_results.push_back(exp_res);
        beats_in++;
        act_count[act]++;
    endtask

    task automatic run_random(int count);
        action_t     act;
        logic [31:0] n;
        logic [15:0] d;
        for (int i = 0; i < count; i++)
        begin
            act = ($urandom_range(29) == 0) ? ACT_RSVD : action_t'($urandom_range(2));
            n   = pick_word();
            d   = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(300));
            // mul-div mostly gets a legal multiplier and nonzero divisor
            if (act == ACT_MUL_DIV && $urandom_range(9) != 0)
            begin
                n = $urandom_range(65535);
                if (d == 0)
                    d = 1;
            end
            send_beat(act, pick_word(), n, pick_word(),
                      ($urandom_range(2) == 0) ? 31'($urandom_range(1000)) : 31'($urandom),
                      d, 1'b0, '{0, 0, 1'b0});
        end
    endtask

    // Receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Result checker: each accepted beat against the oldest expectation
    always @(posedge clk)
    begin
        scaled_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_out++;
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $display("%0t: result beat with nothing expected: res=%0d rem=%0d flag=%0b",
                         $time, $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
                         m_axis_tuser[0]);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser[0]) flagged_out++;
                if (m_axis_tdata[31:0] !== want.res || m_axis_tdata[63:32] !== want.rem
                    || m_axis_tuser[0] !== want.flag)
                begin
                    fail_count++;
                    $display("%0t: expected res=%0d rem=%0d flag=%0b, got res=%0d rem=%0d flag=%0b",
                             $time, want.res, want.rem, want.flag,
                             $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
                             m_axis_tuser[0]);
                end
            end
        end
    end

    // Watchdog: cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        scaled_result_t typed_res;
        fail_count    = 0;
        beats_in      = 0;
        beats_out     = 0;
        flagged_out   = 0;
        idle_cycles   = 0;
        act_count     = '{0, 0, 0, 0};
        tx_idle_pct   = 23;
        rx_idle_pct   = 86;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_MUL_ADD;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (op_table[i])
        begin
            typed_res = '{op_table[i].res, op_table[i].rem, op_table[i].flag};
            send_beat(op_table[i].act, op_table[i].x, op_table[i].n, op_table[i].y,
                      op_table[i].lim, op_table[i].d, op_table[i].typed, typed_res);
        end

        // hold off until the pipeline has drained completely
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);

        run_random(RAND_ITEMS / 3);
        tx_idle_pct = 86;
        rx_idle_pct = 23;
        run_random(RAND_ITEMS / 3);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3));
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Covered %0d beats in, %0d out (%0d flagged)", beats_in, beats_out,
                 flagged_out);
        $display("By action: mul-add %0d, div %0d, mul-div %0d, reserved %0d",
                 act_count[0], act_count[1], act_count[2], act_count[3]);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
hdl/smdu_pkg.sv
hdl/smdu_front.sv
hdl/smdu_div.sv
hdl/smdu_back.sv
hdl/scaled_mul_div_unit_core.sv
tb/tb.sv
